>>> design/min_max_midpoint_window_filter_unit_assert.svh
// Assertion macros for the window filter RTL.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef MIN_MAX_MIDPOINT_WINDOW_FILTER_UNIT_ASSERT_SVH
`define MIN_MAX_MIDPOINT_WINDOW_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// cond holds at every edge
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("window filter check failed");
// cause at an edge brings effect at the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cause) |-> (effect)) \
        else $error("window filter check failed");
// cause at an edge brings effect at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cause) |=> (effect)) \
        else $error("window filter check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, cause, effect)
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect)
`endif
`endif

>>> design/mmmw_pkg.sv
`timescale 1ns / 1ps
package mmmw_pkg;
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int ROW_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    // filter modes
    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_MID = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0]      MODE_RESET   = MODE_MIN;
    localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic   kind;
        t_pixel pixel;
    } t_in_word;

    typedef struct packed {
        t_pixel value;
        logic   end_of_row;
        logic   end_of_frame;
    } t_out_word;

    // lowest and highest sample seen so far
    typedef struct packed {
        t_pixel lo;
        t_pixel hi;
    } t_span;
endpackage

>>> design/mmmw_line_buf.sv
`timescale 1ns / 1ps
module mmmw_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_byp;
    logic              r_byp_sel;

    // read-first array; forward a same-cycle write to the same column
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q       <= mem[i_rd_addr];
            r_byp     <= i_wr_data;
            r_byp_sel <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp_sel ? r_byp : r_q;
endmodule

>>> design/mmmw_cell.sv
`timescale 1ns / 1ps
module mmmw_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_keep,
    input  mmmw_pkg::t_span i_col,
    input  mmmw_pkg::t_span i_run,
    output mmmw_pkg::t_span o_col,
    output mmmw_pkg::t_span o_run
);
    import mmmw_pkg::*;

    t_span r_col;

    // hold one window column, advance it to the neighbor on each word
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // fold this column into the running span when it lies inside the image
    always_comb begin
        o_run = i_run;
        if (i_keep) begin
            if (r_col.lo < i_run.lo) begin
                o_run.lo = r_col.lo;
            end
            if (r_col.hi > i_run.hi) begin
                o_run.hi = r_col.hi;
            end
        end
    end

    assign o_col = r_col;
endmodule

>>> design/min_max_midpoint_window_filter_unit.sv
`timescale 1ns / 1ps
`include "min_max_midpoint_window_filter_unit_assert.svh"
// Channel   Direction  Handshake                Word
// ------    ---------  -----------------------  ---------------------------------
// in        sink       i_in_valid / o_in_stall  i_in_word  {kind, pixel}
// out       source     o_out_valid / i_out_stall o_out_word {value, end_of_row, end_of_frame}
// cfg       sink       i_cfg_we                 i_cfg_index, i_cfg_data
//
// One input word per clock while o_in_stall is low; a result passes the stage B registers,
// the column cells and the output register after the word completing its window is taken.
// That rate is set by the line buffer: one read and one write of the column array
// per word, with the read data registered.
// Reset is synchronous, active low; it clears all control state, no clearing pass.
// Input stall rises only when the output register and its skid entry are both full.
module min_max_midpoint_window_filter_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int WINDOW    = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mmmw_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mmmw_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [mmmw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmmw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mmmw_pkg::*;

    localparam int HALF    = WINDOW / 2;
    localparam int CB      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int XW      = WB + 1;
    localparam int CMPW    = (WB > FW_W) ? WB : FW_W;
    localparam int LAG_MAX = HALF * MAX_WIDTH + HALF;
    localparam int LB      = $clog2(LAG_MAX + 1);
    localparam int LB_W    = (WINDOW - 1) * PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]      r_mode;
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RESET;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode         <= i_cfg_data[1:0];
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the skid entry is full
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_skid_valid;
    logic en;
    logic accept;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && en;

    // ------------------------------------------------------------------
    // Stage A: position tracking on the accepted word.
    // Every word advances the input raster position, also past the frame's
    // pixel count, so the line buffer keeps shifting during the drain.
    // Results start once HALF rows and HALF pixels have gone in.
    // ------------------------------------------------------------------
    logic               r_first;
    logic [WB-1:0]      r_lat_w;
    logic [FH_W-1:0]    r_lat_h;
    logic [CB-1:0]      r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [CB-1:0]      r_out_col;
    logic [FH_W-1:0]    r_out_row;
    logic [LB-1:0]      r_pre;

    logic [WB-1:0]      cfg_w;
    logic [WB-1:0]      eff_w;
    logic [FH_W-1:0]    eff_h;
    logic [LB-1:0]      lag;
    logic               emit;
    logic               eor;
    logic               eof;
    logic               in_wrap;
    logic [XW-1:0]      col_span;
    logic [WINDOW-1:0]  row_keep;
    logic [WINDOW-1:0]  col_keep;

    always_comb begin
        // clamp width into 1..MAX_WIDTH; frame size is taken on the first word
        if (r_frame_width == '0) begin
            cfg_w = WB'(1);
        end else if (CMPW'(r_frame_width) > CMPW'(MAX_WIDTH)) begin
            cfg_w = WB'(MAX_WIDTH);
        end else begin
            cfg_w = WB'(r_frame_width);
        end
        eff_w = r_first ? cfg_w : r_lat_w;
        if (r_first) begin
            eff_h = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
        end else begin
            eff_h = r_lat_h;
        end
        lag      = LB'(HALF) * LB'(cfg_w) + LB'(HALF);
        emit     = !r_first && (r_pre == '0);
        eor      = (WB'(r_out_col) + WB'(1)) == eff_w;
        eof      = eor && ((r_out_row + FH_W'(1)) == eff_h);
        in_wrap  = (WB'(r_in_col) + WB'(1)) == eff_w;
        col_span = XW'(r_out_col) + XW'(HALF);
        for (int k = 0; k < WINDOW; k++) begin
            // tap k is the row k above the incoming word: keep it inside the frame
            row_keep[k] = (r_in_row >= ROW_W'(k)) &&
                          ((r_in_row - ROW_W'(k)) < ROW_W'(eff_h));
            // cell k holds column (center + HALF - k): keep it inside the row
            col_keep[k] = (col_span >= XW'(k)) &&
                          ((col_span - XW'(k)) < XW'(eff_w));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pre     <= '0;
        end else if (accept) begin
            if (r_first) begin
                r_first <= 1'b0;
                r_pre   <= lag - LB'(1);
            end else if (!emit) begin
                r_pre <= r_pre - LB'(1);
            end
            if (emit && eof) begin
                // last result of the frame: rewind for the next frame
                r_first   <= 1'b1;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + CB'(1);
                end
                if (emit) begin
                    if (eor) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + FH_W'(1);
                    end else begin
                        r_out_col <= r_out_col + CB'(1);
                    end
                end
            end
        end
    end

    // latched frame size for the rest of the frame
    always_ff @(posedge i_clk) begin
        if (accept && r_first) begin
            r_lat_w <= eff_w;
            r_lat_h <= eff_h;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: line buffer read data arrives, build the column summary
    // ------------------------------------------------------------------
    logic              r_b_valid;
    logic              r_b_emit;
    logic              r_b_eor;
    logic              r_b_eof;
    t_pixel            r_b_pixel;
    logic [CB-1:0]     r_b_col;
    logic [WINDOW-1:0] r_b_row_keep;
    logic [WINDOW-1:0] r_b_col_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_emit     <= emit;
            r_b_eor      <= eor;
            r_b_eof      <= eof;
            r_b_pixel    <= i_in_word.pixel;
            r_b_col      <= r_in_col;
            r_b_row_keep <= row_keep;
            r_b_col_keep <= col_keep;
        end
    end

    logic [LB_W-1:0] lb_rd_data;
    logic [LB_W-1:0] lb_wr_data;
    logic            lb_wr_en;

    // write the column back shifted down one row, newest sample on top
    assign lb_wr_en   = en && r_b_valid;
    assign lb_wr_data = {lb_rd_data[LB_W-PIX_W-1:0], r_b_pixel};

    mmmw_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CB),
        .DATA_W (LB_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_in_col),
        .i_wr_en   (lb_wr_en),
        .i_wr_addr (r_b_col),
        .i_wr_data (lb_wr_data),
        .o_rd_data (lb_rd_data)
    );

    t_pixel tap [WINDOW];
    t_span  col_in;

    always_comb begin
        tap[0] = r_b_pixel;
        for (int k = 1; k < WINDOW; k++) begin
            tap[k] = lb_rd_data[(k-1)*PIX_W +: PIX_W];
        end
    end

    // column min and max over the rows that lie inside the frame
    always_comb begin
        col_in.lo = PIX_MAX;
        col_in.hi = PIX_MIN;
        for (int k = 0; k < WINDOW; k++) begin
            if (r_b_row_keep[k]) begin
                if (tap[k] < col_in.lo) begin
                    col_in.lo = tap[k];
                end
                if (tap[k] > col_in.hi) begin
                    col_in.hi = tap[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: row of column cells. Cell 0 holds the newest column; the
    // running span ripples through the row and drops columns that fall
    // outside the image, which clips the window at the left and right edges.
    // ------------------------------------------------------------------
    logic              r_c_valid;
    logic              r_c_emit;
    logic              r_c_eor;
    logic              r_c_eof;
    logic [WINDOW-1:0] r_c_col_keep;
    logic              cell_shift;

    assign cell_shift = en && r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_shift) begin
            r_c_emit     <= r_b_emit;
            r_c_eor      <= r_b_eor;
            r_c_eof      <= r_b_eof;
            r_c_col_keep <= r_b_col_keep;
        end
    end

    t_span col_link [WINDOW];
    t_span run_link [WINDOW+1];

    assign col_link[0]    = col_in;
    assign run_link[0].lo = PIX_MAX;
    assign run_link[0].hi = PIX_MIN;

    for (genvar j = 0; j < WINDOW; j++) begin : g_cell
        if (j < WINDOW - 1) begin : g_mid
            mmmw_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (cell_shift),
                .i_keep  (r_c_col_keep[j]),
                .i_col   (col_link[j]),
                .i_run   (run_link[j]),
                .o_col   (col_link[j+1]),
                .o_run   (run_link[j+1])
            );
        end else begin : g_last
            mmmw_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (cell_shift),
                .i_keep  (r_c_col_keep[j]),
                .i_col   (col_link[j]),
                .i_run   (run_link[j]),
                .o_col   (),
                .o_run   (run_link[j+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Mode select and output register with one skid entry
    // ------------------------------------------------------------------
    t_span           win;
    logic [PIX_W:0]  mid_sum;
    t_out_word       new_word;
    logic            push;
    logic            take;
    t_out_word       r_out_word;
    t_out_word       r_skid_word;

    assign win     = run_link[WINDOW];
    assign mid_sum = {1'b0, win.lo} + {1'b0, win.hi};

    always_comb begin
        unique case (r_mode)
            MODE_MIN: new_word.value = win.lo;
            MODE_MAX: new_word.value = win.hi;
            MODE_MID: new_word.value = mid_sum[PIX_W:1];
            default:  new_word.value = mid_sum[PIX_W:1];
        endcase
        new_word.end_of_row   = r_c_eor;
        new_word.end_of_frame = r_c_eof;
    end

    assign push = en && r_c_valid && r_c_emit;
    assign take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid entry into the output register
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_word <= r_skid_word;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid_word <= new_word;
            end else begin
                r_out_word <= new_word;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid)
    `ASSERT_IMPLY(a_skid_only_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && i_out_stall))
    `ASSERT_NEXT(a_frame_end_rewinds, i_clk, i_rst_n, accept && emit && eof, r_first && (r_in_row == '0) && (r_out_row == '0))
    `ASSERT_IMPLY(a_out_pos_in_frame, i_clk, i_rst_n, !r_first, (WB'(r_out_col) < r_lat_w) && (r_out_row < r_lat_h))
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import mmmw_pkg::*;

    localparam int MAX_W     = 1024;
    localparam int HALF      = 2;           // half of the 5x5 window
    localparam int RING_ROWS = 10;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 8;       // output drains through the pipeline registers plus the skid entry
    localparam int TAIL_CYCLES   = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    // codes the package has no name for
    localparam logic [1:0]           MODE_UNDEF = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    // 3x3 patch for the directed frame: both extremes and a middle value
    localparam t_pixel PATCH [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0,
                                     8'd255, 8'd255, 8'd0};

    typedef enum int {SHAPE_SMALL, SHAPE_PRESSURE, SHAPE_WIDE, SHAPE_TALL} t_shape;

    // Track the filter: line ring, frame positions and registers, and the
    // filtered words still owed by the block.
    class window_filter_tracker;
        t_pixel ring [RING_ROWS][MAX_W];
        logic [1:0]  mode_r;
        logic [10:0] width_r;
        logic [11:0] height_r;
        int unsigned in_col, in_row, out_col, out_row;
        int unsigned seen, lat_w, lat_h, lat_lag;
        t_out_word   filtered_due[$];
        int          faults;

        function new();
            mode_r   = MODE_RESET;
            width_r  = WIDTH_RESET;
            height_r = HEIGHT_RESET;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            seen = 0; lat_w = 0; lat_h = 0; lat_lag = 0;
            faults = 0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_MODE:   mode_r   = d[1:0];
                CFG_WIDTH:  width_r  = d[10:0];
                CFG_HEIGHT: height_r = d[11:0];
                default: ;
            endcase
        endfunction

        // min, max or midpoint over the window clipped to the frame
        function t_pixel window_value();
            int unsigned r0, r1, c0, c1;
            t_pixel      lo, hi, v;
            logic [8:0]  sum;
            r0 = (out_row >= HALF) ? out_row - HALF : 0;
            r1 = (out_row + HALF < lat_h) ? out_row + HALF : lat_h - 1;
            c0 = (out_col >= HALF) ? out_col - HALF : 0;
            c1 = (out_col + HALF < lat_w) ? out_col + HALF : lat_w - 1;
            lo = PIX_MAX;
            hi = PIX_MIN;
            for (int unsigned r = r0; r <= r1; r++) begin
                for (int unsigned c = c0; c <= c1; c++) begin
                    v = ring[r % RING_ROWS][c % MAX_W];
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                end
            end
            case (mode_r)
                MODE_MIN: return lo;
                MODE_MAX: return hi;
                default: begin
                    sum = {1'b0, lo} + {1'b0, hi};
                    return sum[8:1];
                end
            endcase
        endfunction

        function void take_word(t_in_word w);
            int unsigned total;
            t_out_word   res;
            // latch the frame size on its first word
            if (seen == 0) begin
                lat_w = width_r;
                if (lat_w == 0) lat_w = 1;
                if (lat_w > MAX_W) lat_w = MAX_W;
                lat_h = height_r;
                if (lat_h == 0) lat_h = 1;
                lat_lag = HALF * lat_w + HALF;
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
            total = lat_w * lat_h;
            // position decides: store inside the pixel count whatever the kind says
            if (seen < total) begin
                ring[in_row % RING_ROWS][in_col % MAX_W] = w.pixel;
                in_col++;
                if (in_col >= lat_w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            seen++;
            if (seen <= lat_lag) return;
            res.end_of_row   = (out_col + 1 == lat_w);
            res.end_of_frame = res.end_of_row && (out_row + 1 == lat_h);
            res.value        = window_value();
            filtered_due.push_back(res);
            if (res.end_of_frame) begin
                seen = 0;
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end else if (res.end_of_row) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (filtered_due.size() == 0) begin
                if (faults < REPORT_LIMIT)
                    $display("unexpected filtered word: value %0d eor %b eof %b",
                             got.value, got.end_of_row, got.end_of_frame);
                faults++;
                return;
            end
            want = filtered_due.pop_front();
            if (got.value !== want.value || got.end_of_row !== want.end_of_row ||
                got.end_of_frame !== want.end_of_frame) begin
                if (faults < REPORT_LIMIT)
                    $display({"filtered word mismatch: expected value %0d eor %b eof %b,",
                              " got value %0d eor %b eof %b"},
                             want.value, want.end_of_row, want.end_of_frame,
                             got.value, got.end_of_row, got.end_of_frame);
                faults++;
            end
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_word              in_word;
    logic                  out_valid;
    logic                  out_stall;
    t_out_word             out_word;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    window_filter_tracker sb;
    int send_idle_pct;
    int stall_pct;
    bit hold_request;

    min_max_midpoint_window_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic t_pixel random_pixel();
        case ($urandom_range(9))
            0: return PIX_MIN;
            1: return PIX_MAX;
            default: return t_pixel'($urandom);
        endcase
    endfunction

    // Offer one word, idling first at the phase's rate; hold it until taken.
    task automatic send_word(input logic kind, input t_pixel pix);
        t_in_word w;
        w.kind  = kind;
        w.pixel = pix;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_word(w);
    endtask

    // Write one register; drop the enable for a clock so back-to-back writes
    // never lower and raise it in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.note_reg(idx, d);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait out every owed word, then let the pipeline empty:
    // words that owe nothing may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Choose the next frame's settings; mode and the upper data bits are random.
    task automatic pick_config(input t_shape shape);
        logic [CFG_DATA_W-1:0] d;
        int unsigned w, h;
        case (shape)
            SHAPE_WIDE: begin
                w = 120;        // long line, few rows
                h = 2;
            end
            SHAPE_TALL: begin
                w = 1;
                h = 300;
            end
            SHAPE_PRESSURE: begin
                w = 16;
                h = 6;
            end
            default: begin
                case ($urandom_range(19))
                    0:       w = 0;
                    1:       w = $urandom_range(40, 13);
                    2:       w = 1;
                    default: w = $urandom_range(12, 1);
                endcase
                case ($urandom_range(19))
                    0:       h = 0;
                    1:       h = $urandom_range(20, 9);
                    default: h = $urandom_range(8, 1);
                endcase
            end
        endcase
        d = CFG_DATA_W'($urandom);
        d[1:0] = 2'($urandom_range(3));
        write_reg(CFG_MODE, d);
        d = CFG_DATA_W'($urandom);
        d[10:0] = w[10:0];
        write_reg(CFG_WIDTH, d);
        write_reg(CFG_HEIGHT, h[11:0]);
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // Send one whole frame, drain ticks included. The next frame's settings go
    // in either partway through (the size must not apply until the frame ends,
    // while the mode applies at once) or after it.
    task automatic run_frame(input t_shape next_shape, output int unsigned n);
        int unsigned fw, fh, pix, k;
        bit mid;
        fw = sb.width_r;
        if (fw == 0) fw = 1;
        if (fw > MAX_W) fw = MAX_W;
        fh = sb.height_r;
        if (fh == 0) fh = 1;
        pix = fw * fh;
        n   = pix + HALF * fw + HALF;
        mid = ($urandom_range(2) == 0);
        k   = mid ? $urandom_range(n - 1, 1) : n;
        for (int unsigned i = 0; i < n; i++) begin
            if (i == k) begin
                settle();
                pick_config(next_shape);
            end
            // mostly honest kinds, with a few that disagree with position
            if (i < pix)
                send_word($urandom_range(19) == 0, random_pixel());
            else
                send_word($urandom_range(19) != 0, random_pixel());
        end
        if (!mid) begin
            settle();
            pick_config(next_shape);
        end
    endtask

    initial begin : stimulus
        int unsigned n, budget;
        int          frame_no;
        t_shape      next_shape;
        sb = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-pixel frame from a zero width and height, undefined mode.
        // Width data carries a stray bit above the field.
        write_reg(CFG_MODE, {10'h3FF, MODE_UNDEF});
        write_reg(CFG_WIDTH, 12'h800);
        write_reg(CFG_HEIGHT, 12'h000);
        write_reg(CFG_SPARE, 12'hFFF);
        send_word(1'b0, PIX_MAX);
        send_word(1'b1, PIX_MIN);
        send_word(1'b0, 8'd77);         // pixel-marked word past the frame: drain
        send_word(1'b1, PIX_MAX);
        send_word(1'b0, PIX_MIN);

        // 3x3 frame: a drain-marked word inside the pixels is still stored;
        // switch mode live partway and queue the next frame's size.
        settle();
        write_reg(CFG_MODE, MODE_MID);
        write_reg(CFG_WIDTH, 12'd3);
        write_reg(CFG_HEIGHT, 12'd3);
        for (int i = 0; i < 17; i++) begin
            if (i == 12) begin
                settle();
                write_reg(CFG_MODE, MODE_MIN);
            end
            if (i == 14) begin
                settle();
                write_reg(CFG_MODE, MODE_MAX);
                write_reg(CFG_WIDTH, 12'd2);
                write_reg(CFG_HEIGHT, 12'd1);
            end
            send_word((i == 4) || (i >= 9 && i != 10), (i < 9) ? PATCH[i] : random_pixel());
        end

        // Random frames, rotating the idling phase every two frames.
        budget   = 0;
        frame_no = 0;
        while (budget < RANDOM_ITEMS) begin
            case ((frame_no / 2) % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 61; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 61; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            // back the output up once while words keep coming
            if (frame_no == 8) hold_request = 1'b1;
            case (frame_no)
                4:       next_shape = SHAPE_WIDE;
                7:       next_shape = SHAPE_PRESSURE;
                11:      next_shape = SHAPE_TALL;
                default: next_shape = SHAPE_SMALL;
            endcase
            run_frame(next_shape, n);
            budget += n;
            frame_no++;
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Take filtered words; stall at the phase's rate, or hold off a long
    // stretch when asked so the block fills and stalls its input.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_stall   <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // End the run if no word moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/mmmw_pkg.sv
design/mmmw_line_buf.sv
design/mmmw_cell.sv
design/min_max_midpoint_window_filter_unit.sv
tb/tb.sv
